// File: design/vdi_pkg.sv
// Package for the vertex dedup indexer: depth constants and payload types.
package vdi_pkg;
    localparam int TABLE_DEPTH = 1024;
    localparam int ADDR_W      = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
    localparam int IDX_W       = 10;
    localparam int KEY_W       = 256;

    typedef struct packed {
        logic [31:0] pos_x;
        logic [31:0] pos_y;
        logic [31:0] pos_z;
        logic [31:0] tex_u;
        logic [31:0] tex_v;
        logic [31:0] nrm_x;
        logic [31:0] nrm_y;
        logic [31:0] nrm_z;
        logic        last_of_mesh;
    } t_vtx_in;

    typedef struct packed {
        logic [IDX_W-1:0] out_index;
        logic             is_new;
        logic             table_full;
    } t_vtx_out;
endpackage

// File: design/vertex_dedup_indexer.sv
// Vertex dedup indexer: returns a dense index per distinct vertex of a mesh.
//
// Input channel i_in_valid/o_in_ready carries one vertex (eight raw 32-bit
// words plus last_of_mesh). Output channel o_out_valid/i_out_ready carries one
// result per vertex: out_index, is_new, table_full.
// The distinct vertices of the current mesh sit in one key memory, 256 bits
// wide, with a registered read. Lookup scans the stored entries in order, each
// entry with a read step then a compare step, and stops at the first match.
// The scan examines no entries for an empty store and up to the distinct
// count on a miss.
// A miss appends the vertex at the next index. With the store full a miss
// reports table_full with index 0. last_of_mesh empties the store after its
// item. One item is in work at a time; the next is taken once the result is
// in the output register, even if the receiver has not yet taken it.
// Reset clears the distinct count and the handshake state; no memory sweep.
// A stalled receiver holds the result; the block finishes the next item and
// waits with it until the output register frees.
module vertex_dedup_indexer (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  vdi_pkg::t_vtx_in  i_in_data,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output vdi_pkg::t_vtx_out o_out_data
);
    import vdi_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_RD   = 2'd1;
    localparam logic [1:0] S_CMP  = 2'd2;
    localparam logic [1:0] S_DONE = 2'd3;

    logic [KEY_W-1:0] r_mem [TABLE_DEPTH];
    logic [KEY_W-1:0] r_rd_data;

    logic [1:0]        r_state, n_state;
    logic [CNT_W-1:0]  r_count, n_count;
    logic [ADDR_W-1:0] r_addr, n_addr;
    logic              r_hit, n_hit;
    logic [KEY_W-1:0]  r_key, n_key;
    logic              r_last, n_last;
    logic              r_out_valid, n_out_valid;
    t_vtx_out          r_out, n_out;

    logic              mem_we;
    logic [CNT_W-1:0]  addr_next;
    logic [31:0]       addr_wide;
    logic [31:0]       count_wide;
    logic              out_free;

    assign out_free   = !r_out_valid || i_out_ready;
    assign addr_next  = CNT_W'(r_addr) + CNT_W'(1);
    assign addr_wide  = 32'(r_addr);
    assign count_wide = 32'(r_count);

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_addr      = r_addr;
        n_hit       = r_hit;
        n_key       = r_key;
        n_last      = r_last;
        n_out_valid = r_out_valid;
        n_out       = r_out;
        mem_we      = 1'b0;
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_key  = {i_in_data.pos_x, i_in_data.pos_y, i_in_data.pos_z,
                              i_in_data.tex_u, i_in_data.tex_v, i_in_data.nrm_x,
                              i_in_data.nrm_y, i_in_data.nrm_z};
                    n_last = i_in_data.last_of_mesh;
                    n_addr = '0;
                    n_hit  = 1'b0;
                    n_state = (r_count == '0) ? S_DONE : S_RD;
                end
            end
            S_RD: begin
                n_state = S_CMP;
            end
            S_CMP: begin
                if (r_rd_data == r_key) begin
                    n_hit   = 1'b1;
                    n_state = S_DONE;
                end else if (addr_next == r_count) begin
                    n_state = S_DONE;
                end else begin
                    n_addr  = addr_next[ADDR_W-1:0];
                    n_state = S_RD;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out.is_new     = 1'b0;
                    n_out.table_full = 1'b0;
                    if (r_hit) begin
                        n_out.out_index = addr_wide[IDX_W-1:0];
                    end else if (r_count < CNT_W'(TABLE_DEPTH)) begin
                        mem_we          = 1'b1;
                        n_out.out_index = count_wide[IDX_W-1:0];
                        n_out.is_new    = 1'b1;
                        n_count         = r_count + CNT_W'(1);
                    end else begin
                        n_out.out_index  = '0;
                        n_out.table_full = 1'b1;
                    end
                    if (r_last) begin
                        n_count = '0;
                    end
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // key memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[r_count[ADDR_W-1:0]] <= r_key;
        end
        if (r_state == S_RD) begin
            r_rd_data <= r_mem[r_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
        r_addr <= n_addr;
        r_hit  <= n_hit;
        r_key  <= n_key;
        r_last <= n_last;
        r_out  <= n_out;
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;
endmodule

// File: design/vdi_checker.sv
// Port-level checker for the vertex dedup indexer, bound to the top level.
module vdi_checker (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_in_valid,
    input logic              o_in_ready,
    input logic              o_out_valid,
    input logic              i_out_ready,
    input vdi_pkg::t_vtx_out o_out_data
);
    import vdi_pkg::*;

    a_flags_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_out_data.is_new && o_out_data.table_full))
        else $error("is_new and table_full both set");

    a_full_index_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.table_full) |-> (o_out_data.out_index == '0))
        else $error("table_full with nonzero index");

    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("second transaction taken while one is in work");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_out_data)))
        else $error("stalled result dropped or changed");
endmodule

bind vertex_dedup_indexer vdi_checker u_vdi_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);

// File: sim/vertex_dedup_indexer_tb.sv
// Testbench for vertex_dedup_indexer: queued vertex stimulus, predicted indices, result checks.
module vertex_dedup_indexer_tb;
    import vdi_pkg::*;

    logic     i_clk;
    logic     i_rst_n;
    logic     i_in_valid;
    logic     o_in_ready;
    t_vtx_in  i_in_data;
    logic     o_out_valid;
    logic     i_out_ready;
    t_vtx_out o_out_data;

    vertex_dedup_indexer u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_data  (i_in_data),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out_data (o_out_data)
    );

    t_vtx_in  vertex_queue[$];
    t_vtx_out result_queue[$];
    t_vtx_out last_result;
    logic [IDX_W-1:0] mesh_index_map[bit [KEY_W-1:0]];
    int mesh_distinct;
    int send_idle_pct;
    int recv_idle_pct;
    int errors;
    bit in_taken;
    t_vtx_in mesh_pool[$];

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    // exact-bit dedup of one vertex against the current mesh
    function automatic t_vtx_out lookup_vertex(t_vtx_in v);
        t_vtx_out r;
        bit [KEY_W-1:0] key;
        key = {v.pos_x, v.pos_y, v.pos_z, v.tex_u, v.tex_v, v.nrm_x, v.nrm_y, v.nrm_z};
        r = '0;
        if (mesh_index_map.exists(key)) begin
            r.out_index = mesh_index_map[key];
        end else if (mesh_distinct < TABLE_DEPTH) begin
            mesh_index_map[key] = mesh_distinct[IDX_W-1:0];
            r.out_index = mesh_distinct[IDX_W-1:0];
            r.is_new = 1'b1;
            mesh_distinct++;
        end else begin
            r.table_full = 1'b1;
        end
        if (v.last_of_mesh) begin
            mesh_index_map.delete();
            mesh_distinct = 0;
        end
        return r;
    endfunction

    // driver
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || in_taken) begin
            if (vertex_queue.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                i_in_data  <= vertex_queue.pop_front();
                i_in_valid <= 1'b1;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
        i_out_ready <= i_rst_n && ($urandom_range(99) >= recv_idle_pct);
        in_taken = 1'b0;
    end

    // monitor
    always @(posedge i_clk) begin
        if (i_rst_n && i_in_valid && o_in_ready) begin
            result_queue = {result_queue, lookup_vertex(i_in_data)};
            in_taken = 1'b1;
        end
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (result_queue.size() == 0) begin
                $error("result transaction with nothing expected");
                errors++;
            end else begin
                last_result = result_queue.pop_front();
                if (o_out_data.out_index !== last_result.out_index) begin
                    $error("out_index expected %0d actual %0d",
                           last_result.out_index, o_out_data.out_index);
                    errors++;
                end
                if (o_out_data.is_new !== last_result.is_new) begin
                    $error("is_new expected %0b actual %0b",
                           last_result.is_new, o_out_data.is_new);
                    errors++;
                end
                if (o_out_data.table_full !== last_result.table_full) begin
                    $error("table_full expected %0b actual %0b",
                           last_result.table_full, o_out_data.table_full);
                    errors++;
                end
            end
        end
    end

    function automatic t_vtx_in random_vertex();
        t_vtx_in v;
        v = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
             $urandom, 1'b0};
        return v;
    endfunction

    function automatic t_vtx_in near_copy(t_vtx_in v);
        t_vtx_in c;
        int w;
        int b;
        c = v;
        w = $urandom_range(7);
        // flip one bit of one word
        b = 32*w + 1 + $urandom_range(31);
        c[b] = ~c[b];
        return c;
    endfunction

    // meshes with heavy vertex reuse and close misses
    task automatic queue_meshes(input int n_items);
        int sent;
        int mesh_len;
        int k;
        int pick;
        t_vtx_in v;
        sent = 0;
        while (sent < n_items) begin
            mesh_len = ($urandom_range(9) == 0) ? $urandom_range(60, 200) : $urandom_range(1, 32);
            mesh_pool.delete();
            for (k = 0; k < mesh_len; k++) begin
                pick = $urandom_range(99);
                if (mesh_pool.size() > 0 && pick < 55) begin
                    v = mesh_pool[$urandom_range(mesh_pool.size() - 1)];
                end else if (mesh_pool.size() > 0 && pick < 70) begin
                    v = near_copy(mesh_pool[$urandom_range(mesh_pool.size() - 1)]);
                end else begin
                    v = random_vertex();
                end
                v.last_of_mesh = (k == mesh_len - 1);
                mesh_pool = {mesh_pool, v};
                vertex_queue = {vertex_queue, v};
            end
            sent += mesh_len;
        end
    endtask

    task automatic wait_drained();
        while (vertex_queue.size() > 0 || i_in_valid || result_queue.size() > 0)
            @(posedge i_clk);
    endtask

    initial begin
        t_vtx_in v;
        t_vtx_in fill_base;
        int k;
        errors        = 0;
        mesh_distinct = 0;
        in_taken      = 1'b0;
        send_idle_pct = 18;
        recv_idle_pct = 58;
        i_rst_n       = 1'b0;
        i_in_valid    = 1'b0;
        i_out_ready   = 1'b0;
        i_in_data     = '0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: extremes, hits, near miss, end of mesh, reuse after clear
        v = '0;
        vertex_queue = {vertex_queue, v};
        v = '1;
        v.last_of_mesh = 1'b0;
        vertex_queue = {vertex_queue, v};
        v = '0;
        vertex_queue = {vertex_queue, v};
        v.nrm_z = 32'h0000_0001;
        vertex_queue = {vertex_queue, v};
        v = '0;
        v.pos_x = 32'h8000_0000;
        vertex_queue = {vertex_queue, v};
        v = '1;
        vertex_queue = {vertex_queue, v};
        v = '0;
        v.nrm_z = 32'h0000_0001;
        vertex_queue = {vertex_queue, v};
        v = '1;
        v.pos_y = 32'h7fff_ffff;
        v.last_of_mesh = 1'b1;
        vertex_queue = {vertex_queue, v};
        v = '1;
        vertex_queue = {vertex_queue, v};
        v = '0;
        vertex_queue = {vertex_queue, v};
        v.last_of_mesh = 1'b1;
        vertex_queue = {vertex_queue, v};
        v = '1;
        v.last_of_mesh = 1'b0;
        vertex_queue = {vertex_queue, v};

        queue_meshes(100);
        // hold off until the block is empty
        wait_drained();

        send_idle_pct = 58;
        recv_idle_pct = 18;
        // fill the store to capacity, then overflow
        fill_base = random_vertex();
        for (k = 0; k < TABLE_DEPTH; k++) begin
            v = fill_base;
            v.pos_x = k;
            vertex_queue = {vertex_queue, v};
        end
        v = fill_base;
        v.pos_x = TABLE_DEPTH - 1;
        vertex_queue = {vertex_queue, v};
        v.pos_x = 0;
        vertex_queue = {vertex_queue, v};
        v = random_vertex();
        vertex_queue = {vertex_queue, v};
        vertex_queue = {vertex_queue, v};
        v = fill_base;
        v.pos_x = 32'hffff_ffff;
        v.last_of_mesh = 1'b1;
        vertex_queue = {vertex_queue, v};
        vertex_queue = {vertex_queue, v};
        wait_drained();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        queue_meshes(60);
        wait_drained();

        repeat (50) @(posedge i_clk);
        if (errors == 0 && result_queue.size() == 0) begin
            $display("PASS vertex_dedup_indexer");
        end else begin
            $display("FAIL vertex_dedup_indexer");
        end
        $finish;
    end

    initial begin
        #80_000_000;
        $display("FAIL vertex_dedup_indexer");
        $finish;
    end
endmodule
